FILE: rtl/wtmt_pkg.sv
// Shared types and constants for the windowed trimmed mean tracker.
package wtmt_pkg;

    localparam int DATA_W = 24;

    localparam int DEF_HISTORY_DEPTH = 128;
    localparam int DEF_SHORT_WINDOW  = 5;
    localparam int DEF_MID_WINDOW    = 12;
    localparam int DEF_LONG_WINDOW   = 100;

    // divider: reciprocal estimate, then one correction step
    localparam int DIV_STEPS = 2;

    typedef logic [DATA_W-1:0] wtmt_data_t;

    // controller -> datapath
    typedef struct packed {
        logic start;     // take the sample, write history, open the walk
        logic walk;      // issue one history read
        logic div_load;  // load trimmed sums into the dividers
        logic div_step;  // one divider step in every lane
        logic finish;    // update minima, load the result register
    } wtmt_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic walk_last;
        logic div_last;
        logic out_busy;
    } wtmt_status_t;

endpackage

FILE: rtl/wtmt_sample_if.sv
// Input channel: one time sample per transaction.
interface wtmt_sample_if import wtmt_pkg::*; ();
    logic       valid;
    logic       ready;
    wtmt_data_t sample_ms;

    modport source (output valid, output sample_ms, input ready);
    modport sink   (input valid, input sample_ms, output ready);
endinterface

FILE: rtl/wtmt_result_if.sv
// Output channel: trimmed means and running minima per transaction.
interface wtmt_result_if import wtmt_pkg::*; ();
    logic       valid;
    logic       ready;
    wtmt_data_t short_trim_mean;
    wtmt_data_t mid_trim_mean;
    wtmt_data_t long_trim_mean;
    wtmt_data_t lowest_sample;
    wtmt_data_t lowest_short_mean;
    wtmt_data_t lowest_mid_mean;
    wtmt_data_t lowest_long_mean;

    modport source (
        output valid, input ready,
        output short_trim_mean, output mid_trim_mean, output long_trim_mean,
        output lowest_sample, output lowest_short_mean, output lowest_mid_mean,
        output lowest_long_mean
    );
    modport sink (
        input valid, output ready,
        input short_trim_mean, input mid_trim_mean, input long_trim_mean,
        input lowest_sample, input lowest_short_mean, input lowest_mid_mean,
        input lowest_long_mean
    );
endinterface

FILE: rtl/wtmt_ctrl.sv
// Sequencing state machine: accept, walk history, divide, deliver.
module wtmt_ctrl import wtmt_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  wtmt_status_t status,
    output wtmt_cmd_t    cmd
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_WALK   = 6'b000010,
        ST_DRAIN  = 6'b000100,
        ST_LOAD   = 6'b001000,
        ST_DIVIDE = 6'b010000,
        ST_FINISH = 6'b100000
    } wtmt_state_t;

    wtmt_state_t state_reg;
    wtmt_state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                cmd.walk = 1'b1;
                if (status.walk_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            // last read data lands in the accumulators
            ST_DRAIN:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                cmd.div_load = 1'b1;
                state_next   = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!status.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_start_walks: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> state_reg == ST_WALK)
        else $error("walk did not follow an accepted sample");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVIDE && status.div_last) |=> state_reg == ST_FINISH)
        else $error("divide phase did not end on the last step");

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state register lost its one-hot code");

endmodule

FILE: rtl/wtmt_lane.sv
// One window: accumulate sum/min/max, then rounded division by a reciprocal multiply.
module wtmt_lane import wtmt_pkg::*; #(
    parameter int WIN           = DEF_SHORT_WINDOW,
    parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH,
    parameter int SUM_W         = DATA_W + 7,
    parameter int K_W           = 7,
    parameter int CNT_W         = 7
) (
    input  logic             clk,
    input  logic             clear,
    input  logic             acc_en,
    input  logic [K_W-1:0]   acc_k,
    input  wtmt_data_t       acc_data,
    input  logic             div_load,
    input  logic             div_step,
    input  logic [CNT_W-1:0] count,
    output wtmt_data_t       mean
);

    // round half up folded in: mean = floor((x + floor(d/2)) / d)
    localparam int DIVISOR = WIN - 2;
    localparam int M_W     = SUM_W + 1;
    localparam int PROD_W  = SUM_W + M_W;
    // floor(2^SUM_W / d): the estimate is exact or one low
    localparam logic [M_W-1:0]   RECIP = M_W'((64'd1 << SUM_W) / 64'(DIVISOR));
    localparam logic [SUM_W-1:0] DIV_S = SUM_W'(DIVISOR);
    localparam logic [SUM_W-1:0] HALF  = SUM_W'(DIVISOR / 2);

    logic [SUM_W-1:0] sum_reg;
    wtmt_data_t       lo_reg;
    wtmt_data_t       hi_reg;
    logic [SUM_W-1:0] num_reg;
    logic [SUM_W-1:0] quo_reg;
    logic             fix_reg;

    logic              in_win;
    logic [SUM_W-1:0]  dividend;
    logic [PROD_W-1:0] product;
    logic [SUM_W-1:0]  q_est;
    logic [SUM_W-1:0]  rem_est;
    logic              carry;
    logic              full;

    always_comb
    begin
        in_win   = acc_en && (32'(acc_k) < 32'(WIN));
        dividend = sum_reg - SUM_W'(lo_reg) - SUM_W'(hi_reg) + HALF;
        // constant multiplier
        product  = PROD_W'(num_reg) * PROD_W'(RECIP);
        q_est    = product[SUM_W +: SUM_W];
        rem_est  = num_reg - quo_reg * DIV_S;
        carry    = rem_est >= DIV_S;
        full     = (32'(count) >= 32'(WIN)) && (WIN <= HISTORY_DEPTH);
        mean     = full ? quo_reg[DATA_W-1:0] : '0;
    end

    always_ff @(posedge clk)
    begin
        if (clear)
        begin
            sum_reg <= '0;
            lo_reg  <= '1;
            hi_reg  <= '0;
        end
        else if (in_win)
        begin
            sum_reg <= sum_reg + SUM_W'(acc_data);
            if (acc_data < lo_reg)
            begin
                lo_reg <= acc_data;
            end
            if (acc_data > hi_reg)
            begin
                hi_reg <= acc_data;
            end
        end

        if (div_load)
        begin
            num_reg <= dividend;
            fix_reg <= 1'b0;
        end
        else if (div_step)
        begin
            fix_reg <= 1'b1;
            if (!fix_reg)
            begin
                quo_reg <= q_est;
            end
            else
            begin
                quo_reg <= quo_reg + SUM_W'(carry);
            end
        end
    end

endmodule

FILE: rtl/wtmt_datapath.sv
// History memory, walk pointers, three window lanes, minima and result register.
module wtmt_datapath import wtmt_pkg::*; #(
    parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH,
    parameter int SHORT_WINDOW  = DEF_SHORT_WINDOW,
    parameter int MID_WINDOW    = DEF_MID_WINDOW,
    parameter int LONG_WINDOW   = DEF_LONG_WINDOW,
    parameter int LARGEST       = DEF_LONG_WINDOW,
    parameter int EFF_MAX       = DEF_LONG_WINDOW,
    parameter int SUM_W         = DATA_W + 7,
    parameter int K_W           = 7,
    parameter int CNT_W         = 7,
    parameter int AW            = 7,
    parameter int DC_W          = 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  wtmt_cmd_t            cmd,
    output wtmt_status_t         status,
    input  wtmt_data_t           sample_ms,
    wtmt_result_if.source        results
);

    wtmt_data_t       mem [HISTORY_DEPTH];

    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [CNT_W-1:0] seen_reg;
    logic [K_W-1:0]   k_reg;
    logic [K_W-1:0]   rd_k_reg;
    logic             rd_vld_reg;
    logic [DC_W-1:0]  div_cnt_reg;
    wtmt_data_t       rd_data_reg;
    wtmt_data_t       sample_reg;

    wtmt_data_t       min_sample_reg;
    wtmt_data_t       min_short_reg;
    wtmt_data_t       min_mid_reg;
    wtmt_data_t       min_long_reg;
    wtmt_data_t       min_sample_next;
    wtmt_data_t       min_short_next;
    wtmt_data_t       min_mid_next;
    wtmt_data_t       min_long_next;

    logic             out_valid_reg;
    wtmt_data_t       out_short_reg;
    wtmt_data_t       out_mid_reg;
    wtmt_data_t       out_long_reg;

    wtmt_data_t       mean_short;
    wtmt_data_t       mean_mid;
    wtmt_data_t       mean_long;

    // zero means "none yet", so a zero tracked value always gets replaced
    function automatic wtmt_data_t track_low(input wtmt_data_t low, input wtmt_data_t v);
        return ((low == '0) || (v < low)) ? v : low;
    endfunction

    always_comb
    begin
        status.walk_last = (32'(k_reg) + 32'd1 >= 32'(seen_reg))
                        || (32'(k_reg) + 32'd1 >= 32'(EFF_MAX));
        status.div_last  = div_cnt_reg == DC_W'(DIV_STEPS - 1);
        status.out_busy  = out_valid_reg && !results.ready;

        min_sample_next = track_low(min_sample_reg, sample_reg);
        min_short_next  = track_low(min_short_reg, mean_short);
        min_mid_next    = track_low(min_mid_reg, mean_mid);
        min_long_next   = track_low(min_long_reg, mean_long);
    end

    // history store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            mem[wr_ptr_reg] <= sample_ms;
        end
        if (cmd.walk)
        begin
            rd_data_reg <= mem[rd_ptr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            seen_reg       <= '0;
            k_reg          <= '0;
            rd_k_reg       <= '0;
            rd_vld_reg     <= 1'b0;
            div_cnt_reg    <= '0;
            min_sample_reg <= '0;
            min_short_reg  <= '0;
            min_mid_reg    <= '0;
            min_long_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= cmd.walk;
            rd_k_reg   <= k_reg;

            if (cmd.start)
            begin
                rd_ptr_reg <= wr_ptr_reg;
                wr_ptr_reg <= (wr_ptr_reg == AW'(HISTORY_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
                k_reg      <= '0;
                if (32'(seen_reg) < 32'(LARGEST))
                begin
                    seen_reg <= seen_reg + 1'b1;
                end
            end
            else if (cmd.walk)
            begin
                rd_ptr_reg <= (rd_ptr_reg == '0) ? AW'(HISTORY_DEPTH - 1) : rd_ptr_reg - 1'b1;
                k_reg      <= k_reg + 1'b1;
            end

            if (cmd.div_load)
            begin
                div_cnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg + 1'b1;
            end

            if (cmd.finish)
            begin
                min_sample_reg <= min_sample_next;
                min_short_reg  <= min_short_next;
                min_mid_reg    <= min_mid_next;
                min_long_reg   <= min_long_next;
                out_valid_reg  <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            sample_reg <= sample_ms;
        end
        if (cmd.finish)
        begin
            out_short_reg <= mean_short;
            out_mid_reg   <= mean_mid;
            out_long_reg  <= mean_long;
        end
    end

    wtmt_lane #(
        .WIN(SHORT_WINDOW), .HISTORY_DEPTH(HISTORY_DEPTH),
        .SUM_W(SUM_W), .K_W(K_W), .CNT_W(CNT_W)
    ) u_short (
        .clk(clk), .clear(cmd.start), .acc_en(rd_vld_reg), .acc_k(rd_k_reg),
        .acc_data(rd_data_reg), .div_load(cmd.div_load), .div_step(cmd.div_step),
        .count(seen_reg), .mean(mean_short)
    );

    wtmt_lane #(
        .WIN(MID_WINDOW), .HISTORY_DEPTH(HISTORY_DEPTH),
        .SUM_W(SUM_W), .K_W(K_W), .CNT_W(CNT_W)
    ) u_mid (
        .clk(clk), .clear(cmd.start), .acc_en(rd_vld_reg), .acc_k(rd_k_reg),
        .acc_data(rd_data_reg), .div_load(cmd.div_load), .div_step(cmd.div_step),
        .count(seen_reg), .mean(mean_mid)
    );

    wtmt_lane #(
        .WIN(LONG_WINDOW), .HISTORY_DEPTH(HISTORY_DEPTH),
        .SUM_W(SUM_W), .K_W(K_W), .CNT_W(CNT_W)
    ) u_long (
        .clk(clk), .clear(cmd.start), .acc_en(rd_vld_reg), .acc_k(rd_k_reg),
        .acc_data(rd_data_reg), .div_load(cmd.div_load), .div_step(cmd.div_step),
        .count(seen_reg), .mean(mean_long)
    );

    assign results.valid             = out_valid_reg;
    assign results.short_trim_mean   = out_short_reg;
    assign results.mid_trim_mean     = out_mid_reg;
    assign results.long_trim_mean    = out_long_reg;
    assign results.lowest_sample     = min_sample_reg;
    assign results.lowest_short_mean = min_short_reg;
    assign results.lowest_mid_mean   = min_mid_reg;
    assign results.lowest_long_mean  = min_long_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !(out_valid_reg && !results.ready))
        else $error("result register loaded while a result was still pending");

    a_seen_cap: assert property (@(posedge clk) disable iff (!rst_n)
        32'(seen_reg) <= 32'(LARGEST))
        else $error("sample count passed the largest window");

    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg |-> (32'(rd_k_reg) < 32'(EFF_MAX)) && (32'(rd_k_reg) < 32'(seen_reg)))
        else $error("history read beyond the filled part of the window");

endmodule

FILE: rtl/windowed_trimmed_mean_tracker.sv
// Top level: trimmed moving averages over three windows plus running minima.
// Each sample: walk N history entries, N = min(samples stored, largest window that
//   fits the history), then the divide steps, then the result register load.
// One sample at a time, bounded by the single history read port; a result held
//   downstream stalls only the final step.
// Reset (async, active low) clears pointers, sample count, minima and the result
//   valid; the history memory is not cleared and is only read where written.
module windowed_trimmed_mean_tracker import wtmt_pkg::*; #(
    parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH,
    parameter int SHORT_WINDOW  = DEF_SHORT_WINDOW,
    parameter int MID_WINDOW    = DEF_MID_WINDOW,
    parameter int LONG_WINDOW   = DEF_LONG_WINDOW
) (
    input  logic          clk,
    input  logic          rst_n,
    wtmt_sample_if.sink   samples,
    wtmt_result_if.source results
);

    // windows longer than the history never fill; they do not stretch the walk
    localparam int S_EFF   = (SHORT_WINDOW <= HISTORY_DEPTH) ? SHORT_WINDOW : 1;
    localparam int M_EFF   = (MID_WINDOW <= HISTORY_DEPTH) ? MID_WINDOW : 1;
    localparam int L_EFF   = (LONG_WINDOW <= HISTORY_DEPTH) ? LONG_WINDOW : 1;
    localparam int SM_EFF  = (S_EFF > M_EFF) ? S_EFF : M_EFF;
    localparam int EFF_MAX = (SM_EFF > L_EFF) ? SM_EFF : L_EFF;

    // the sample count saturates at the largest window, fitting or not
    localparam int SM_WIN  = (SHORT_WINDOW > MID_WINDOW) ? SHORT_WINDOW : MID_WINDOW;
    localparam int LARGEST = (SM_WIN > LONG_WINDOW) ? SM_WIN : LONG_WINDOW;

    localparam int SUM_W = DATA_W + $clog2(EFF_MAX);  // exact window sum
    localparam int K_W   = $clog2(EFF_MAX + 1);       // walk index
    localparam int CNT_W = $clog2(LARGEST + 1);       // samples seen
    localparam int AW    = $clog2(HISTORY_DEPTH);     // history address
    localparam int DC_W  = $clog2(DIV_STEPS);         // divider step counter

    wtmt_cmd_t    cmd;
    wtmt_status_t status;

    // controller only sequences; it never sees payload
    wtmt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (samples.valid),
        .in_ready (samples.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath holds the history, lanes, minima and the output register,
    // so a finished result can wait while the next sample is accepted
    wtmt_datapath #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .SHORT_WINDOW  (SHORT_WINDOW),
        .MID_WINDOW    (MID_WINDOW),
        .LONG_WINDOW   (LONG_WINDOW),
        .LARGEST       (LARGEST),
        .EFF_MAX       (EFF_MAX),
        .SUM_W         (SUM_W),
        .K_W           (K_W),
        .CNT_W         (CNT_W),
        .AW            (AW),
        .DC_W          (DC_W)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .sample_ms (samples.sample_ms),
        .results   (results)
    );

endmodule

FILE: sim/tb_windowed_trimmed_mean_tracker.sv
// Self-checking testbench: windowed trimmed mean tracker against a cycle-free predictor.
module tb_windowed_trimmed_mean_tracker import wtmt_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    // ------------------------------------------------------------------
    // Run shape
    // ------------------------------------------------------------------
    localparam int N_DIRECTED     = 24;
    localparam int RANDOM_ITEMS   = 600;
    localparam int HOLD_AT        = 150;    // random item where the receiver holds off
    localparam int HOLD_CYCLES    = 2000;   // length of that hold-off
    localparam int CALM_FROM      = 250;    // stretch of random items with no idling
    localparam int CALM_LEN       = 100;
    localparam int DRAIN_AT       = 420;    // sender waits for every result here
    localparam int LATENCY_MAX    = 105;    // result delay with the long window full
    localparam int WATCHDOG_LIMIT = 10000;  // quiet cycles before we call it hung
    localparam int REPORT_LIMIT   = 10;

    localparam int WIDEST =
        (DEF_LONG_WINDOW > DEF_MID_WINDOW)
            ? ((DEF_LONG_WINDOW > DEF_SHORT_WINDOW) ? DEF_LONG_WINDOW : DEF_SHORT_WINDOW)
            : ((DEF_MID_WINDOW > DEF_SHORT_WINDOW) ? DEF_MID_WINDOW : DEF_SHORT_WINDOW);

    // One result transaction, field order matches the result interface.
    typedef struct packed {
        wtmt_data_t short_m;
        wtmt_data_t mid_m;
        wtmt_data_t long_m;
        wtmt_data_t low_s;
        wtmt_data_t low_short;
        wtmt_data_t low_mid;
        wtmt_data_t low_long;
    } tracker_out_t;

    localparam int N_FIELDS = 7;

    // Directed stimulus row: the sample, and a typed-in result where it is obvious.
    typedef struct packed {
        wtmt_data_t   sample;
        logic         typed;
        tracker_out_t want;
    } directed_row_t;

    // ------------------------------------------------------------------
    // Clock, reset, channels, block
    // ------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always #5 clk = ~clk;

    wtmt_sample_if sample_ch ();
    wtmt_result_if result_ch ();

    windowed_trimmed_mean_tracker uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (sample_ch),
        .results (result_ch)
    );

    // ------------------------------------------------------------------
    // Predictor state: its own ring of samples, fill count and minima
    // ------------------------------------------------------------------
    wtmt_data_t  history [DEF_HISTORY_DEPTH];
    int unsigned wr_slot;
    int unsigned stored;
    wtmt_data_t  low_sample;
    wtmt_data_t  low_short;
    wtmt_data_t  low_mid;
    wtmt_data_t  low_long;

    // Expected results, oldest first.
    tracker_out_t pending_means [$];

    // Bookkeeping
    int  mismatches      = 0;
    int  results_checked = 0;
    int  samples_sent    = 0;
    int  long_full_hits  = 0;
    int  holdoffs_done   = 0;
    int  quiet_cycles    = 0;
    bit  calm            = 1'b0;   // no idling on either side while set
    bit  hold_pending    = 1'b0;   // sender asks the receiver for a long hold-off

    string field_names [N_FIELDS] = '{
        "short_trim_mean", "mid_trim_mean", "long_trim_mean", "lowest_sample",
        "lowest_short_mean", "lowest_mid_mean", "lowest_long_mean"
    };

    // Rows 1-4: window not yet full, so only the lowest sample moves.
    // A zero sample leaves the minimum at "none"; the next nonzero one replaces it.
    directed_row_t directed_rows [N_DIRECTED] = '{
        '{24'h000000, 1'b1, '{24'd0, 24'd0, 24'd0, 24'd0,      24'd0, 24'd0, 24'd0}},
        '{24'hFFFFFF, 1'b1, '{24'd0, 24'd0, 24'd0, 24'hFFFFFF, 24'd0, 24'd0, 24'd0}},
        '{24'h000001, 1'b1, '{24'd0, 24'd0, 24'd0, 24'd1,      24'd0, 24'd0, 24'd0}},
        '{24'hFFFFFF, 1'b1, '{24'd0, 24'd0, 24'd0, 24'd1,      24'd0, 24'd0, 24'd0}},
        // short window fills here; a zero sample drops the lowest sample back to none
        '{24'h000000, 1'b0, '0},
        // all-max short window
        '{24'hFFFFFF, 1'b0, '0},
        '{24'hFFFFFF, 1'b0, '0},
        '{24'hFFFFFF, 1'b0, '0},
        '{24'hFFFFFF, 1'b0, '0},
        '{24'hFFFFFF, 1'b0, '0},
        '{24'h800000, 1'b0, '0},
        // middle window fills on this one
        '{24'h555555, 1'b0, '0},
        '{24'hAAAAAA, 1'b0, '0},
        '{24'h000001, 1'b0, '0},
        '{24'h7FFFFF, 1'b0, '0},
        // small values: rounding of the quotient, ties go up
        '{24'h000002, 1'b0, '0},
        '{24'h000003, 1'b0, '0},
        '{24'h000004, 1'b0, '0},
        '{24'h00000A, 1'b0, '0},
        '{24'h00000B, 1'b0, '0},
        '{24'h00000D, 1'b0, '0},
        '{24'h000011, 1'b0, '0},
        '{24'h000100, 1'b0, '0},
        '{24'hFFFF00, 1'b0, '0}
    };

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Olympic mean of the newest 'win' samples: drop one min and one max,
    // divide by win-2, round half up.
    function automatic wtmt_data_t olympic_mean(int unsigned win, int unsigned newest);
        logic [63:0] total;
        logic [63:0] d;
        logic [63:0] q;
        logic [63:0] r;
        wtmt_data_t  lo;
        wtmt_data_t  hi;
        wtmt_data_t  v;
        if (win < 3 || win > DEF_HISTORY_DEPTH || stored < win)
            return '0;
        total = '0;
        lo    = '1;
        hi    = '0;
        for (int unsigned k = 0; k < win; k++)
        begin
            v = history[(newest + DEF_HISTORY_DEPTH - k) % DEF_HISTORY_DEPTH];
            total += 64'(v);
            if (v < lo) lo = v;
            if (v > hi) hi = v;
        end
        total -= 64'(lo) + 64'(hi);
        d = 64'(win - 2);
        q = total / d;
        r = total % d;
        if (2 * r >= d) q++;
        return q[DATA_W-1:0];
    endfunction

    // Zero means "none yet": any value replaces it.
    function automatic wtmt_data_t keep_low(wtmt_data_t cur, wtmt_data_t v);
        return (cur == '0 || v < cur) ? v : cur;
    endfunction

    function automatic tracker_out_t predict_trimmed_means(wtmt_data_t value);
        tracker_out_t o;
        int unsigned  newest;
        newest          = wr_slot;
        history[newest] = value;
        wr_slot         = (newest + 1) % DEF_HISTORY_DEPTH;
        if (stored < WIDEST) stored++;

        o.short_m = olympic_mean(DEF_SHORT_WINDOW, newest);
        o.mid_m   = olympic_mean(DEF_MID_WINDOW, newest);
        o.long_m  = olympic_mean(DEF_LONG_WINDOW, newest);

        low_sample = keep_low(low_sample, value);
        low_short  = keep_low(low_short, o.short_m);
        low_mid    = keep_low(low_mid, o.mid_m);
        low_long   = keep_low(low_long, o.long_m);

        o.low_s     = low_sample;
        o.low_short = low_short;
        o.low_mid   = low_mid;
        o.low_long  = low_long;
        if (stored >= DEF_LONG_WINDOW) long_full_hits++;
        return o;
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Optional idle gap, then hold one sample transaction until the block takes it.
    // Gaps are sometimes long enough to land anywhere in the block's walk/divide.
    task automatic offer_sample(input wtmt_data_t value, input logic typed,
                                input tracker_out_t typed_want);
        int           gap;
        tracker_out_t predicted;
        gap = 0;
        if (!calm && $urandom_range(99) < 38)
            gap = ($urandom_range(3) == 0) ? $urandom_range(20, 160) : $urandom_range(1, 8);
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid     <= 1'b1;
        sample_ch.sample_ms <= value;
        // ready is sampled before this edge's updates, same as the block sees it
        do @(posedge clk); while (!sample_ch.ready);
        predicted = predict_trimmed_means(value);
        pending_means.push_back(typed ? typed_want : predicted);
        samples_sent++;
    endtask

    // Drop valid and sit until every expected result has come back.
    task automatic wait_for_drain();
        sample_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_means.size() != 0);
    endtask

    initial
    begin : stimulus
        wtmt_data_t  value;
        int          pick;
        int unsigned pace_ms;
        int unsigned jitter;

        sample_ch.valid     <= 1'b0;
        sample_ch.sample_ms <= '0;
        wr_slot    = 0;
        stored     = 0;
        low_sample = '0;
        low_short  = '0;
        low_mid    = '0;
        low_long   = '0;
        pace_ms    = 12000;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: extremes, fill points of the short and middle windows, rounding.
        for (int i = 0; i < N_DIRECTED; i++)
            offer_sample(directed_rows[i].sample, directed_rows[i].typed,
                         directed_rows[i].want);

        // Random part: mostly clustered solve times around a drifting pace,
        // with outliers, zeros, extremes and full-range noise mixed in.
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == HOLD_AT)
                hold_pending = 1'b1;
            if (i == DRAIN_AT)
                wait_for_drain();
            calm = (i >= CALM_FROM && i < CALM_FROM + CALM_LEN);

            if ($urandom_range(49) == 0)
                pace_ms = $urandom_range(2000, 60000);
            pick = $urandom_range(99);
            if (pick < 4)
                value = '0;
            else if (pick < 8)
                value = pick[0] ? '1 : 24'd1;
            else if (pick < 28)
                value = 24'($urandom);
            else if (pick < 34)
                value = 24'(pace_ms * $urandom_range(2, 5));   // a bad solve
            else
            begin
                jitter = $urandom_range(0, pace_ms / 4);
                value  = 24'(pace_ms - pace_ms / 8 + jitter);
            end
            offer_sample(value, 1'b0, '0);
        end
        calm = 1'b0;

        // End of stimulus: let everything drain, then allow for any stray result.
        wait_for_drain();
        repeat (2 * LATENCY_MAX) @(posedge clk);

        $display("Summary: %0d sample transactions (%0d directed, %0d random), %0d results",
                 samples_sent, N_DIRECTED, RANDOM_ITEMS, results_checked);
        $display("  long window full on %0d, history wrapped %0d times, %0d long hold-offs",
                 long_full_hits, samples_sent / DEF_HISTORY_DEPTH, holdoffs_done);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver side: random back-pressure, one long hold-off, calm stretch
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        int stall;
        stall = 0;
        result_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_pending)
            begin
                // Hold off long enough that the block fills and stalls its input
                // while the sender keeps offering.
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_pending = 1'b0;
                holdoffs_done++;
            end
            else if (calm)
                result_ch.ready <= 1'b1;
            else if (stall > 0)
            begin
                stall--;
                result_ch.ready <= 1'b0;
            end
            else if ($urandom_range(99) < 38)
            begin
                result_ch.ready <= 1'b0;
                if ($urandom_range(19) == 0)
                    stall = $urandom_range(5, 60);
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Checker: each result transaction against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin : check_result
            tracker_out_t got;
            tracker_out_t want;
            wtmt_data_t   got_f;
            wtmt_data_t   want_f;
            got = '{result_ch.short_trim_mean, result_ch.mid_trim_mean,
                    result_ch.long_trim_mean, result_ch.lowest_sample,
                    result_ch.lowest_short_mean, result_ch.lowest_mid_mean,
                    result_ch.lowest_long_mean};
            if (pending_means.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%t: result transaction with nothing pending", $realtime);
            end
            else
            begin
                want = pending_means.pop_front();
                for (int f = 0; f < N_FIELDS; f++)
                begin
                    // first struct field sits in the top bits
                    want_f = want[(N_FIELDS - 1 - f) * DATA_W +: DATA_W];
                    got_f  = got[(N_FIELDS - 1 - f) * DATA_W +: DATA_W];
                    if (got_f !== want_f)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display("%t: result %0d %s expected %0d got %0d", $realtime,
                                     results_checked, field_names[f], want_f, got_f);
                    end
                end
            end
            results_checked++;
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: cycles with no transaction on either channel
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n || (sample_ch.valid && sample_ch.ready)
                   || (result_ch.valid && result_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no transaction for %0d cycles, %0d results still pending",
                     quiet_cycles, pending_means.size());
            $display("Regression FAIL");
            $finish;
        end
    end

endmodule
